// File: design/bfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfpa_pkg;
	localparam int FREE_ENTRIES = 16;
	localparam int USED_ENTRIES = 16;
	localparam int FIW = $clog2(FREE_ENTRIES);
	localparam int UIW = $clog2(USED_ENTRIES);
	localparam logic [15:0] RESET_POOL_BASE = 16'd1000;
	localparam logic [15:0] RESET_POOL_SIZE = 16'd512;
	localparam logic [15:0] RESET_MIN_FRAG = 16'd5;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_INIT = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOFIT = 3'd1,
		ST_USEDFULL = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FREEFULL = 3'd4
	} status_t;

	localparam logic [1:0] REG_POOL_BASE = 2'd0;
	localparam logic [1:0] REG_POOL_SIZE = 2'd1;
	localparam logic [1:0] REG_MIN_FRAG = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] job_id;
		logic [15:0] request_len;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] job_out;
		logic [15:0] region_addr;
		logic [15:0] region_len;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_FREE,
		S_SCAN_USED,
		S_COMMIT,
		S_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_scan;
		logic step_free;
		logic step_used;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic free_last;
		logic used_last;
	} stat_t;
endpackage
`default_nettype wire

// File: design/bfpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bfpa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire bfpa_pkg::stat_t st,
	output bfpa_pkg::cmd_t cmd
);
	import bfpa_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.clr_scan = 1'b1;
					state_d = S_SCAN_FREE;
				end
			end
			S_SCAN_FREE: begin
				cmd.step_free = 1'b1;
				if (st.free_last) state_d = S_SCAN_USED;
			end
			S_SCAN_USED: begin
				cmd.step_used = 1'b1;
				if (st.used_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_commit_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit not followed by result");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// File: design/bfpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module bfpa_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire bfpa_pkg::cmd_t cmd,
	input wire bfpa_pkg::in_item_t in_item,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output bfpa_pkg::stat_t st,
	output bfpa_pkg::out_item_t out_item
);
	import bfpa_pkg::*;

	logic [15:0] base_q, size_q, minf_q;
	logic [15:0] faddr_q [FREE_ENTRIES];
	logic [15:0] flen_q [FREE_ENTRIES];
	logic [FREE_ENTRIES-1:0] fvalid_q;
	logic [15:0] uaddr_q [USED_ENTRIES];
	logic [15:0] ulen_q [USED_ENTRIES];
	logic [7:0] ujob_q [USED_ENTRIES];

	in_item_t req_q;
	logic [FIW-1:0] fi_q;
	logic [UIW-1:0] ui_q;
	// used scan results
	logic uslot_v_q, uhit_v_q;
	logic [UIW-1:0] uslot_q, uhit_q;
	logic [15:0] ra_q, rl_q;
	// free scan results
	logic best_v_q, below_v_q, above_v_q, empty_v_q;
	logic [FIW-1:0] best_q, below_q, above_q, empty_q;
	out_item_t res_q;

	assign st.free_last = (fi_q == FIW'(FREE_ENTRIES - 1));
	assign st.used_last = (ui_q == UIW'(USED_ENTRIES - 1));
	assign out_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RESET_POOL_BASE;
			size_q <= RESET_POOL_SIZE;
			minf_q <= RESET_MIN_FRAG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BASE: base_q <= cfg_data;
				REG_POOL_SIZE: size_q <= cfg_data;
				REG_MIN_FRAG: minf_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// free entry under the scan pointer
	logic [15:0] fa, fl;
	logic [16:0] fend, uend;
	assign fa = faddr_q[fi_q];
	assign fl = flen_q[fi_q];

	// release needs the used hit before the free scan; allocate needs the
	// opposite. both work because release looks up the job in the load cycle
	// over a priority search of used_job comparisons (independent compares)
	logic hit_v;
	logic [UIW-1:0] hit_i;
	always_comb begin
		hit_v = 1'b0;
		hit_i = '0;
		for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
			if (ujob_q[i] == in_item.job_id && in_item.job_id != 8'd0) begin
				hit_v = 1'b1;
				hit_i = UIW'(i);
			end
		end
	end
	assign fend = {1'b0, fa} + {1'b0, fl};
	assign uend = {1'b0, ra_q} + {1'b0, rl_q};

	logic [16:0] lim;
	logic [15:0] init_len;
	assign lim = 17'h10000 - {1'b0, base_q};
	assign init_len = ({1'b0, size_q} > lim) ? lim[15:0] : size_q;

	logic [15:0] bl, left;
	assign bl = flen_q[best_q];
	assign left = bl - req_q.request_len;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
			fi_q <= '0;
			ui_q <= '0;
			uhit_v_q <= hit_v;
			uhit_q <= hit_i;
			ra_q <= uaddr_q[hit_i];
			rl_q <= ulen_q[hit_i];
			uslot_v_q <= 1'b0;
			best_v_q <= 1'b0;
			below_v_q <= 1'b0;
			above_v_q <= 1'b0;
			empty_v_q <= 1'b0;
			uslot_q <= '0;
			best_q <= '0;
			below_q <= '0;
			above_q <= '0;
			empty_q <= '0;
		end
		if (cmd.step_free) begin
			fi_q <= fi_q + 1'b1;
			if (fvalid_q[fi_q]) begin
				if (req_q.request_len <= fl && (!best_v_q || fl < bl)) begin
					best_v_q <= 1'b1;
					best_q <= fi_q;
				end
				if (!below_v_q && fend == {1'b0, ra_q}) begin
					below_v_q <= 1'b1;
					below_q <= fi_q;
				end
				if (!above_v_q && uend == {1'b0, fa}) begin
					above_v_q <= 1'b1;
					above_q <= fi_q;
				end
			end else if (!empty_v_q) begin
				empty_v_q <= 1'b1;
				empty_q <= fi_q;
			end
		end
		if (cmd.step_used) begin
			ui_q <= ui_q + 1'b1;
			if (!uslot_v_q && ujob_q[ui_q] == 8'd0) begin
				uslot_v_q <= 1'b1;
				uslot_q <= ui_q;
			end
		end
		if (cmd.commit) begin
			unique case (mode_t'(req_q.mode))
				MODE_ALLOC: begin
					if (req_q.job_id == 8'd0 || req_q.request_len == 16'd0 || !best_v_q)
						res_q <= '{ST_NOFIT, 8'd0, 16'd0, 16'd0};
					else if (!uslot_v_q) res_q <= '{ST_USEDFULL, 8'd0, 16'd0, 16'd0};
					else begin
						uaddr_q[uslot_q] <= faddr_q[best_q];
						if (left <= minf_q) begin
							res_q <= '{ST_OK, req_q.job_id, faddr_q[best_q], bl};
							ulen_q[uslot_q] <= bl;
						end else begin
							res_q <= '{ST_OK, req_q.job_id, faddr_q[best_q],
								req_q.request_len};
							ulen_q[uslot_q] <= req_q.request_len;
						end
					end
				end
				MODE_RELEASE: begin
					if (!uhit_v_q) res_q <= '{ST_NOTFOUND, 8'd0, 16'd0, 16'd0};
					else if (!below_v_q && !above_v_q && !empty_v_q)
						res_q <= '{ST_FREEFULL, 8'd0, 16'd0, 16'd0};
					else res_q <= '{ST_OK, req_q.job_id, ra_q, rl_q};
				end
				MODE_INIT: res_q <= '{ST_OK, 8'd0, base_q, init_len};
				default: res_q <= '{ST_OK, 8'd0, 16'd0, 16'd0};
			endcase
		end
	end

	// table state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FREE_ENTRIES; i++) begin
				faddr_q[i] <= (i == 0) ? RESET_POOL_BASE : 16'd0;
				flen_q[i] <= (i == 0) ? RESET_POOL_SIZE : 16'd0;
			end
			for (int i = 0; i < USED_ENTRIES; i++) ujob_q[i] <= '0;
			fvalid_q <= FREE_ENTRIES'(1);
		end else if (cmd.commit) begin
			unique case (mode_t'(req_q.mode))
				MODE_ALLOC: begin
					if (req_q.job_id != 8'd0 && req_q.request_len != 16'd0 && best_v_q
							&& uslot_v_q) begin
						ujob_q[uslot_q] <= req_q.job_id;
						if (left <= minf_q) fvalid_q[best_q] <= 1'b0;
						else begin
							faddr_q[best_q] <= faddr_q[best_q] + req_q.request_len;
							flen_q[best_q] <= left;
						end
					end
				end
				MODE_RELEASE: begin
					if (uhit_v_q && (below_v_q || above_v_q || empty_v_q)) begin
						ujob_q[uhit_q] <= 8'd0;
						if (below_v_q && above_v_q) begin
							flen_q[below_q] <= flen_q[below_q] + flen_q[above_q] + rl_q;
							fvalid_q[above_q] <= 1'b0;
						end else if (below_v_q) begin
							flen_q[below_q] <= flen_q[below_q] + rl_q;
						end else if (above_v_q) begin
							flen_q[above_q] <= flen_q[above_q] + rl_q;
							faddr_q[above_q] <= ra_q;
						end else begin
							faddr_q[empty_q] <= ra_q;
							flen_q[empty_q] <= rl_q;
							fvalid_q[empty_q] <= 1'b1;
						end
					end
				end
				MODE_INIT: begin
					for (int i = 0; i < USED_ENTRIES; i++) ujob_q[i] <= '0;
					faddr_q[0] <= base_q;
					flen_q[0] <= init_len;
					fvalid_q <= {{(FREE_ENTRIES - 1){1'b0}}, (init_len != 16'd0)};
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && best_v_q) |-> (fvalid_q[best_q] && bl >= req_q.request_len))
		else $error("best entry does not fit");
	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && uhit_v_q) |-> (ujob_q[uhit_q] == req_q.job_id))
		else $error("release hit mismatch");
	a_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && uslot_v_q) |-> (ujob_q[uslot_q] == 8'd0))
		else $error("allocated slot not empty");
`endif
endmodule
`default_nettype wire

// File: design/best_fit_partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: accept, serial scan of the free table, serial scan of the used table, commit, result
// a new item is accepted only after the previous result beat has been taken
// one item in flight; the result register holds until the output beat is taken
// reset (arst_n low): registers to 1000/512/5, free entry 0 = whole pool, used table empty
module best_fit_partition_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire bfpa_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output bfpa_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import bfpa_pkg::*;
	cmd_t cmd;
	stat_t st;

	// sequencer: idle, free scan, used scan, commit, result beat
	bfpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
	);

	// tables, scan trackers and result register
	bfpa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.st(st), .out_item(out_data)
	);
endmodule
`default_nettype wire
